/* design/rsi_pkg.sv */
// rsi_pkg: widths, constants and bundle types of the ray/sphere test pipeline.
// No dependencies; the interfaces, rsi_mul and the top level refer to it by scoped names.
`default_nettype none

package rsi_pkg;

    localparam int FRAC_BITS = 16;                  // fraction bits of the fixed-point format
    localparam int CW        = 32;                  // coordinate width
    localparam int RAD_W     = CW - 1;              // radius width
    localparam int OC_W      = CW + 1;              // origin - center
    localparam int A_W       = 2 * CW;              // d.d, three squares < 2^64
    localparam int H_W       = 2 * CW + 2;          // oc.d
    localparam int C_W       = 2 * CW + 3;          // oc.oc - r^2
    localparam int B_W       = H_W + 1;             // b = 2 oc.d

    localparam int MUL_W     = C_W + 1;             // signed operand width of the wide multiplier
    localparam int MUL_CHUNK = 23;
    localparam int MUL_NCH   = 3;                   // MUL_CHUNK * MUL_NCH > MUL_W
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_LAT   = 5;

    localparam int X_W       = 2 * H_W;             // h^2 - a*c
    localparam int DISC_W    = X_W - 4;             // non-negative discriminant < 2^128
    localparam int ROOT_W    = DISC_W / 2;
    localparam int NS_W      = B_W + 2;             // -b +/- root
    localparam int N_W       = B_W;                 // chosen positive numerator
    localparam int DEN_W     = A_W + 1;             // 2a
    localparam int T_W       = CW - 1;              // quotient bits kept before saturation
    localparam int NUM_W     = N_W + FRAC_BITS;
    localparam int CMP_W     = (NUM_W > DEN_W + T_W) ? NUM_W : DEN_W + T_W;
    localparam int DT_W      = 2 * CW;              // d * t
    localparam int SUM_W     = DT_W - FRAC_BITS + 1;

    localparam logic [T_W-1:0] T_MAX = '1;

    typedef logic [2:0][CW-1:0] vec3_t;

    typedef struct packed {
        vec3_t o;
        vec3_t d;
    } ray_t;

    typedef struct packed {
        logic           miss;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        ray_t           ray;
    } side_t;

    typedef struct packed {
        logic             miss;
        logic             ovf;
        logic [DEN_W-1:0] den;
        ray_t             ray;
    } dside_t;

endpackage

`default_nettype wire

/* design/rsi_if.sv */
// rsi_in_if / rsi_out_if: valid/ready channels carrying one ray word and one hit word.
// Depends on rsi_pkg for field widths.
`default_nettype none

interface rsi_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsi_pkg::CW-1:0]     origin_x;
    logic signed [rsi_pkg::CW-1:0]     origin_y;
    logic signed [rsi_pkg::CW-1:0]     origin_z;
    logic signed [rsi_pkg::CW-1:0]     dir_x;
    logic signed [rsi_pkg::CW-1:0]     dir_y;
    logic signed [rsi_pkg::CW-1:0]     dir_z;
    logic signed [rsi_pkg::CW-1:0]     center_x;
    logic signed [rsi_pkg::CW-1:0]     center_y;
    logic signed [rsi_pkg::CW-1:0]     center_z;
    logic        [rsi_pkg::RAD_W-1:0]  sphere_radius;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    center_x, center_y, center_z, sphere_radius, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface rsi_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [rsi_pkg::CW-1:0] hit_distance;
    logic signed [rsi_pkg::CW-1:0] hit_x;
    logic signed [rsi_pkg::CW-1:0] hit_y;
    logic signed [rsi_pkg::CW-1:0] hit_z;

    modport source (output valid, hit, hit_distance, hit_x, hit_y, hit_z, input ready);
    modport sink   (input valid, hit, hit_distance, hit_x, hit_y, hit_z, output ready);
endinterface

`default_nettype wire

/* design/rsi_mul.sv */
// rsi_mul: five-stage signed wide multiplier built from 23x23 partial products.
// Depends on rsi_pkg for operand widths and chunking.
`default_nettype none

module rsi_mul (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [rsi_pkg::MUL_W-1:0]   a,
    input  logic signed [rsi_pkg::MUL_W-1:0]   b,
    output logic signed [rsi_pkg::PROD_W-1:0]  p
);

    localparam int CH    = rsi_pkg::MUL_CHUNK;
    localparam int NCH   = rsi_pkg::MUL_NCH;
    localparam int MW    = CH * NCH;
    localparam int PPW   = 2 * CH;
    localparam int ROW_W = PPW + CH * (NCH - 1) + 1;
    localparam int MAG_W = ROW_W + CH * (NCH - 1);

    logic [rsi_pkg::MUL_W-1:0] abs_a, abs_b;
    logic [3:0]                sign_reg;
    logic [MW-1:0]             ma_reg, mb_reg;
    logic [PPW-1:0]            pp_reg [NCH][NCH];
    logic [ROW_W-1:0]          row_next [NCH];
    logic [ROW_W-1:0]          row_reg [NCH];
    logic [MAG_W-1:0]          mag_next;
    logic [rsi_pkg::PROD_W-1:0] mag_reg;
    logic [rsi_pkg::PROD_W-1:0] p_reg;

    assign abs_a = a[rsi_pkg::MUL_W-1] ? rsi_pkg::MUL_W'(-a) : a;
    assign abs_b = b[rsi_pkg::MUL_W-1] ? rsi_pkg::MUL_W'(-b) : b;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NCH; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (CH * j));
            end
        end
        mag_next = '0;
        for (int i = 0; i < NCH; i++)
        begin
            mag_next = mag_next + (MAG_W'(row_reg[i]) << (CH * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= {sign_reg[2:0], a[rsi_pkg::MUL_W-1] ^ b[rsi_pkg::MUL_W-1]};
            ma_reg   <= MW'(abs_a);
            mb_reg   <= MW'(abs_b);
            for (int i = 0; i < NCH; i++)
            begin
                for (int j = 0; j < NCH; j++)
                begin
                    pp_reg[i][j] <= ma_reg[CH*i +: CH] * mb_reg[CH*j +: CH];
                end
            end
            row_reg <= row_next;
            mag_reg <= rsi_pkg::PROD_W'(mag_next);
            p_reg   <= sign_reg[3] ? rsi_pkg::PROD_W'(-mag_reg) : mag_reg;
        end
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

/* design/ray_sphere_intersection_unit.sv */
// ray_sphere_intersection_unit: pipelined ray/sphere quadratic test, one word per cycle unless hits stalls.
// Depends on rsi_pkg, rsi_in_if/rsi_out_if and rsi_mul.
//
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  rays    | in  | origin_x/y/z, dir_x/y/z, center_x/y/z, sphere_radius
//  hits    | out | hit, hit_distance, hit_x/y/z
//
// Takes one word per cycle while hits is not stalled; the pipe's depth comes mostly
// from the 64 one-bit square root stages and the 31 one-bit divide stages.
// Reset (rst_n low, async) clears every valid bit; data registers are not reset.
// A stall on hits freezes the whole pipe with one shared enable, so rays.ready
// drops in the same cycle and no word is dropped or doubled.
`default_nettype none

module ray_sphere_intersection_unit (
    input  logic       clk,
    input  logic       rst_n,
    rsi_in_if.sink     rays,
    rsi_out_if.source  hits
);

    localparam int NMA = 10;    // first-round products: d*d x3, oc*d x3, oc*oc x3, r*r

    logic adv;                  // shared pipeline enable

    // ---------------- stage 1: oc = origin - center ----------------
    logic                                  s1_v_reg;
    rsi_pkg::ray_t                         s1_ray_reg;
    logic [2:0][rsi_pkg::OC_W-1:0]         s1_oc_reg;
    logic [rsi_pkg::RAD_W-1:0]             s1_r_reg;

    // ---------------- first multiply round ----------------
    logic signed [rsi_pkg::MUL_W-1:0]      ma_op [NMA];
    logic signed [rsi_pkg::MUL_W-1:0]      mb_op [NMA];
    logic signed [rsi_pkg::PROD_W-1:0]     mp    [NMA];
    logic [rsi_pkg::MUL_LAT-1:0]           da_v_reg;
    rsi_pkg::ray_t                         da_ray_reg [rsi_pkg::MUL_LAT];

    // ---------------- stage 2: a, h, c ----------------
    logic                                  s2_v_reg;
    logic [rsi_pkg::A_W-1:0]               s2_a_reg;
    logic [rsi_pkg::H_W-1:0]               s2_h_reg;
    logic [rsi_pkg::C_W-1:0]               s2_c_reg;
    rsi_pkg::ray_t                         s2_ray_reg;

    // ---------------- second multiply round: h*h, a*c ----------------
    logic signed [rsi_pkg::PROD_W-1:0]     hh_p, ac_p;
    logic [rsi_pkg::MUL_LAT-1:0]           db_v_reg;
    rsi_pkg::side_t                        db_side_reg [rsi_pkg::MUL_LAT];
    rsi_pkg::side_t                        s2_side;

    // ---------------- stage 3 and square root ----------------
    logic signed [rsi_pkg::X_W-1:0]        quarter_disc;
    rsi_pkg::side_t                        s3_side;
    logic [rsi_pkg::ROOT_W:0]              sq_v_reg;
    logic [rsi_pkg::DISC_W-1:0]            sq_rem_reg  [rsi_pkg::ROOT_W+1];
    logic [rsi_pkg::ROOT_W-1:0]            sq_root_reg [rsi_pkg::ROOT_W+1];
    rsi_pkg::side_t                        sq_side_reg [rsi_pkg::ROOT_W+1];

    // ---------------- stage 4: root choice ----------------
    logic signed [rsi_pkg::NS_W-1:0]       neg_b, n0, n1;
    logic                                  pos0, pos1;
    rsi_pkg::side_t                        s4_side;
    logic                                  s4_v_reg;
    logic [rsi_pkg::N_W-1:0]               s4_n_reg;
    rsi_pkg::side_t                        s4_side_reg;

    // ---------------- stage 5 and divider ----------------
    logic [rsi_pkg::NUM_W-1:0]             num;
    logic [rsi_pkg::DEN_W-1:0]             den;
    rsi_pkg::dside_t                       s5_side;
    logic [rsi_pkg::T_W:0]                 dv_v_reg;
    logic [rsi_pkg::NUM_W-1:0]             dv_rem_reg  [rsi_pkg::T_W+1];
    logic [rsi_pkg::T_W-1:0]               dv_q_reg    [rsi_pkg::T_W+1];
    rsi_pkg::dside_t                       dv_side_reg [rsi_pkg::T_W+1];

    // ---------------- stage 6: d * t ----------------
    rsi_pkg::dside_t                       dv_last;
    logic [rsi_pkg::T_W-1:0]               t_sat;
    logic                                  s6_v_reg;
    logic                                  s6_miss_reg;
    logic [rsi_pkg::T_W-1:0]               s6_t_reg;
    rsi_pkg::vec3_t                        s6_o_reg;
    logic signed [rsi_pkg::DT_W-1:0]       s6_prod_reg [3];

    // ---------------- output register ----------------
    logic signed [rsi_pkg::DT_W-1:0]       prod_sh [3];
    logic signed [rsi_pkg::SUM_W-1:0]      coord_sum [3];
    logic [2:0][rsi_pkg::CW-1:0]           coord_sat;
    logic                                  out_v_reg;
    logic                                  hit_reg;
    logic [rsi_pkg::CW-1:0]                dist_reg;
    logic [2:0][rsi_pkg::CW-1:0]           pt_reg;

    assign adv        = !out_v_reg || hits.ready;
    assign rays.ready = adv;

    // ================= stage 1 =================
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= rays.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ray_reg.o <= {rays.origin_z, rays.origin_y, rays.origin_x};
            s1_ray_reg.d <= {rays.dir_z, rays.dir_y, rays.dir_x};
            s1_oc_reg[0] <= rsi_pkg::OC_W'(rays.origin_x) - rsi_pkg::OC_W'(rays.center_x);
            s1_oc_reg[1] <= rsi_pkg::OC_W'(rays.origin_y) - rsi_pkg::OC_W'(rays.center_y);
            s1_oc_reg[2] <= rsi_pkg::OC_W'(rays.origin_z) - rsi_pkg::OC_W'(rays.center_z);
            s1_r_reg     <= rays.sphere_radius;
        end
    end

    // ================= first multiply round =================
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ma_op[k]     = rsi_pkg::MUL_W'($signed(s1_ray_reg.d[k]));
            mb_op[k]     = rsi_pkg::MUL_W'($signed(s1_ray_reg.d[k]));
            ma_op[3 + k] = rsi_pkg::MUL_W'($signed(s1_oc_reg[k]));
            mb_op[3 + k] = rsi_pkg::MUL_W'($signed(s1_ray_reg.d[k]));
            ma_op[6 + k] = rsi_pkg::MUL_W'($signed(s1_oc_reg[k]));
            mb_op[6 + k] = rsi_pkg::MUL_W'($signed(s1_oc_reg[k]));
        end
        ma_op[9] = $signed(rsi_pkg::MUL_W'(s1_r_reg));
        mb_op[9] = $signed(rsi_pkg::MUL_W'(s1_r_reg));
    end

    for (genvar g = 0; g < NMA; g++)
    begin : g_mul_a
        rsi_mul u_mul (
            .clk (clk),
            .en  (adv),
            .a   (ma_op[g]),
            .b   (mb_op[g]),
            .p   (mp[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            da_v_reg <= '0;
        end
        else if (adv)
        begin
            da_v_reg <= {da_v_reg[rsi_pkg::MUL_LAT-2:0], s1_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            da_ray_reg[0] <= s1_ray_reg;
            for (int i = 1; i < rsi_pkg::MUL_LAT; i++)
            begin
                da_ray_reg[i] <= da_ray_reg[i - 1];
            end
        end
    end

    // ================= stage 2: dot products =================
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= da_v_reg[rsi_pkg::MUL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a_reg   <= rsi_pkg::A_W'(mp[0]) + rsi_pkg::A_W'(mp[1]) + rsi_pkg::A_W'(mp[2]);
            s2_h_reg   <= rsi_pkg::H_W'(mp[3]) + rsi_pkg::H_W'(mp[4]) + rsi_pkg::H_W'(mp[5]);
            s2_c_reg   <= rsi_pkg::C_W'(mp[6]) + rsi_pkg::C_W'(mp[7]) + rsi_pkg::C_W'(mp[8])
                          - rsi_pkg::C_W'(mp[9]);
            s2_ray_reg <= da_ray_reg[rsi_pkg::MUL_LAT-1];
        end
    end

    // ================= second multiply round =================
    rsi_mul u_mul_hh (
        .clk (clk),
        .en  (adv),
        .a   (rsi_pkg::MUL_W'($signed(s2_h_reg))),
        .b   (rsi_pkg::MUL_W'($signed(s2_h_reg))),
        .p   (hh_p)
    );

    rsi_mul u_mul_ac (
        .clk (clk),
        .en  (adv),
        .a   ($signed(rsi_pkg::MUL_W'(s2_a_reg))),
        .b   (rsi_pkg::MUL_W'($signed(s2_c_reg))),
        .p   (ac_p)
    );

    // zero direction is flagged here and rides along as a miss
    always_comb
    begin
        s2_side.miss = (s2_a_reg == '0);
        s2_side.a    = s2_a_reg;
        s2_side.b    = {s2_h_reg, 1'b0};
        s2_side.ray  = s2_ray_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_v_reg <= '0;
        end
        else if (adv)
        begin
            db_v_reg <= {db_v_reg[rsi_pkg::MUL_LAT-2:0], s2_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            db_side_reg[0] <= s2_side;
            for (int i = 1; i < rsi_pkg::MUL_LAT; i++)
            begin
                db_side_reg[i] <= db_side_reg[i - 1];
            end
        end
    end

    // ================= stage 3: discriminant =================
    // disc = 4 (h^2 - a c); when it is non-negative it stays below 2^128
    always_comb
    begin
        quarter_disc = rsi_pkg::X_W'(hh_p) - rsi_pkg::X_W'(ac_p);
        s3_side      = db_side_reg[rsi_pkg::MUL_LAT-1];
        s3_side.miss = db_side_reg[rsi_pkg::MUL_LAT-1].miss || quarter_disc[rsi_pkg::X_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= '0;
        end
        else if (adv)
        begin
            sq_v_reg <= {sq_v_reg[rsi_pkg::ROOT_W-1:0], db_v_reg[rsi_pkg::MUL_LAT-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_rem_reg[0]  <= {quarter_disc[rsi_pkg::DISC_W-3:0], 2'b00};
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= s3_side;
        end
    end

    // one root bit per stage, MSB first; rem holds disc - root^2
    for (genvar j = 0; j < rsi_pkg::ROOT_W; j++)
    begin : g_sqrt
        localparam int K = rsi_pkg::ROOT_W - 1 - j;
        logic [rsi_pkg::DISC_W-1:0] trial;
        logic                       ge;

        always_comb
        begin
            trial = (rsi_pkg::DISC_W'(sq_root_reg[j]) << (K + 1))
                    | (rsi_pkg::DISC_W'(1) << (2 * K));
            ge    = (sq_rem_reg[j] >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j + 1]  <= ge ? (sq_rem_reg[j] - trial) : sq_rem_reg[j];
                sq_root_reg[j + 1] <= sq_root_reg[j] | (rsi_pkg::ROOT_W'(ge) << K);
                sq_side_reg[j + 1] <= sq_side_reg[j];
            end
        end
    end

    // ================= stage 4: pick the nearer positive root =================
    always_comb
    begin
        neg_b = -rsi_pkg::NS_W'($signed(sq_side_reg[rsi_pkg::ROOT_W].b));
        n0    = neg_b - $signed(rsi_pkg::NS_W'(sq_root_reg[rsi_pkg::ROOT_W]));
        n1    = neg_b + $signed(rsi_pkg::NS_W'(sq_root_reg[rsi_pkg::ROOT_W]));
        pos0  = !n0[rsi_pkg::NS_W-1] && (n0 != '0);
        pos1  = !n1[rsi_pkg::NS_W-1] && (n1 != '0);
        s4_side      = sq_side_reg[rsi_pkg::ROOT_W];
        s4_side.miss = sq_side_reg[rsi_pkg::ROOT_W].miss || (!pos0 && !pos1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_v_reg <= sq_v_reg[rsi_pkg::ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_n_reg    <= pos0 ? rsi_pkg::N_W'(n0) : rsi_pkg::N_W'(n1);
            s4_side_reg <= s4_side;
        end
    end

    // ================= stage 5: divider setup =================
    // t = floor(n 2^F / 2a); ovf marks a quotient that does not fit in T_W bits
    always_comb
    begin
        num          = {s4_n_reg, {rsi_pkg::FRAC_BITS{1'b0}}};
        den          = {s4_side_reg.a, 1'b0};
        s5_side.miss = s4_side_reg.miss;
        s5_side.ovf  = (rsi_pkg::CMP_W'(num) >= (rsi_pkg::CMP_W'(den) << rsi_pkg::T_W));
        s5_side.den  = den;
        s5_side.ray  = s4_side_reg.ray;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg <= '0;
        end
        else if (adv)
        begin
            dv_v_reg <= {dv_v_reg[rsi_pkg::T_W-1:0], s4_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0]  <= num;
            dv_q_reg[0]    <= '0;
            dv_side_reg[0] <= s5_side;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar j = 0; j < rsi_pkg::T_W; j++)
    begin : g_div
        localparam int I = rsi_pkg::T_W - 1 - j;
        logic [rsi_pkg::CMP_W-1:0] trial;
        logic                      ge;

        always_comb
        begin
            trial = rsi_pkg::CMP_W'(dv_side_reg[j].den) << I;
            ge    = (rsi_pkg::CMP_W'(dv_rem_reg[j]) >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j + 1]  <= ge ? (dv_rem_reg[j] - rsi_pkg::NUM_W'(trial))
                                         : dv_rem_reg[j];
                dv_q_reg[j + 1]    <= dv_q_reg[j] | (rsi_pkg::T_W'(ge) << I);
                dv_side_reg[j + 1] <= dv_side_reg[j];
            end
        end
    end

    // ================= stage 6: d * t =================
    assign dv_last = dv_side_reg[rsi_pkg::T_W];
    assign t_sat   = dv_last.ovf ? rsi_pkg::T_MAX : dv_q_reg[rsi_pkg::T_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_v_reg <= dv_v_reg[rsi_pkg::T_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_miss_reg <= dv_last.miss;
            s6_t_reg    <= t_sat;
            s6_o_reg    <= dv_last.ray.o;
            for (int k = 0; k < 3; k++)
            begin
                s6_prod_reg[k] <= $signed(dv_last.ray.d[k]) * $signed({1'b0, t_sat});
            end
        end
    end

    // ================= output register: o + floor(d t / 2^F), saturated =================
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_sh[k]   = s6_prod_reg[k] >>> rsi_pkg::FRAC_BITS;
            coord_sum[k] = rsi_pkg::SUM_W'($signed(s6_o_reg[k])) + rsi_pkg::SUM_W'(prod_sh[k]);
            if ((coord_sum[k][rsi_pkg::SUM_W-1:rsi_pkg::CW-1] == '0)
                || (coord_sum[k][rsi_pkg::SUM_W-1:rsi_pkg::CW-1] == '1))
            begin
                coord_sat[k] = coord_sum[k][rsi_pkg::CW-1:0];
            end
            else if (coord_sum[k][rsi_pkg::SUM_W-1])
            begin
                coord_sat[k] = {1'b1, {(rsi_pkg::CW-1){1'b0}}};
            end
            else
            begin
                coord_sat[k] = {1'b0, {(rsi_pkg::CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= s6_v_reg;
        end
    end

    // a miss word carries all-zero fields
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= !s6_miss_reg;
            dist_reg <= s6_miss_reg ? '0 : {1'b0, s6_t_reg};
            pt_reg   <= s6_miss_reg ? '0 : coord_sat;
        end
    end

    assign hits.valid        = out_v_reg;
    assign hits.hit          = hit_reg;
    assign hits.hit_distance = $signed(dist_reg);
    assign hits.hit_x        = $signed(pt_reg[0]);
    assign hits.hit_y        = $signed(pt_reg[1]);
    assign hits.hit_z        = $signed(pt_reg[2]);

endmodule

`default_nettype wire

/* design/rsi_checker.sv */
// rsi_checker: port-level assertions for ray_sphere_intersection_unit, bound below.
// Depends on the port names of the top level only.
`default_nettype none

module rsi_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        hit,
    input  logic [31:0] distance,
    input  logic [31:0] hx,
    input  logic [31:0] hy,
    input  logic [31:0] hz
);

    // a stalled hit word keeps its hit flag and distance
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance))
        else $error("hit word changed while stalled");

    // back-pressure reaches the input in the same cycle
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while output stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> distance == 32'd0 && hx == 32'd0 && hy == 32'd0 && hz == 32'd0)
        else $error("miss word with nonzero fields");

    a_dist_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !distance[31])
        else $error("negative hit distance");

endmodule

bind ray_sphere_intersection_unit rsi_checker u_rsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (rays.ready),
    .out_valid (hits.valid),
    .out_ready (hits.ready),
    .hit       (hits.hit),
    .distance  (hits.hit_distance),
    .hx        (hits.hit_x),
    .hy        (hits.hit_y),
    .hz        (hits.hit_z)
);

`default_nettype wire
